[rtl/gccn_pkg.sv]
// Shared constants, types and per-channel state layout for the code and carrier NCO.
package gccn_pkg;

    localparam int unsigned CHANNELS  = 16;
    localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [5:0]  WORD_BITS = 6'd32;

    typedef enum logic [1:0] {
        ACT_SETUP = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  channel;
        logic [31:0] carrier_word;
        logic [31:0] code_word;
        logic [11:0] start_chip;
        logic [5:0]  start_ms;
        logic [5:0]  start_bit_count;
        logic [11:0] code_length;
        logic [5:0]  ms_per_bit;
        logic [31:0] nav_word;
    } item_t;

    typedef struct packed {
        logic [31:0] carrier_acc;
        logic [31:0] code_acc;
        logic [11:0] chip_count;
        logic [5:0]  period_count;
        logic [5:0]  bits_left;
        logic        word_valid;
        logic        current_bit;
        logic [31:0] bit_store;
        logic [11:0] chips_per_period;
        logic [5:0]  periods_per_bit;
    } chan_state_t;

    typedef struct packed {
        logic word_request;
        logic chip_edge;
    } tick_flags_t;

    localparam chan_state_t RESET_STATE = '{
        carrier_acc:      32'd0,
        code_acc:         32'd0,
        chip_count:       12'd0,
        period_count:     6'd0,
        bits_left:        WORD_BITS,
        word_valid:       1'b0,
        current_bit:      1'b0,
        bit_store:        32'd0,
        chips_per_period: 12'd1023,
        periods_per_bit:  6'd20
    };

endpackage

[rtl/gnss_channel_code_carrier_nco.sv]
// Top level of the multi-channel code and carrier NCO with its channel state memory.
//
// Each word names one channel and sets it up, loads its navigation word or
// advances it one tick; every word yields exactly one result word. All channel
// state sits in one memory with a registered read: the read is registered as a
// word is accepted, update and write-back follow when the output register is
// free; the next word waits for that write-back. A new word is accepted while the
// previous result still waits in the output register. Entries never written
// read as their reset values through per-channel valid flags; no clearing pass.
module gnss_channel_code_carrier_nco
    import gccn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  channel,
    input  logic [31:0] carrier_word,
    input  logic [31:0] code_word,
    input  logic [11:0] start_chip,
    input  logic [5:0]  start_ms,
    input  logic [5:0]  start_bit_count,
    input  logic [11:0] code_length,
    input  logic [5:0]  ms_per_bit,
    input  logic [31:0] nav_word,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  out_channel,
    output logic [31:0] carrier_phase,
    output logic [31:0] code_phase,
    output logic [11:0] chip_index,
    output logic [5:0]  ms_index,
    output logic [5:0]  bit_count,
    output logic        nav_bit,
    output logic        word_request,
    output logic        chip_edge
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } fsm_t;

    fsm_t        state_reg, state_next;
    item_t       item_reg;
    chan_state_t mem [CHANNELS];
    logic [CHANNELS-1:0] written_reg;
    chan_state_t rd_data_reg;
    logic        rd_valid_reg;
    chan_state_t cur_state;
    chan_state_t new_state;
    tick_flags_t flags;
    logic [CH_W-1:0] rd_idx;
    logic [CH_W-1:0] wr_idx;
    logic        accept;
    logic        live;
    logic        commit;
    logic        out_free;

    logic        result_valid_reg;
    logic [3:0]  out_channel_reg;
    chan_state_t out_state_reg;
    tick_flags_t out_flags_reg;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign rd_idx     = CH_W'(channel);
    assign wr_idx     = CH_W'(item_reg.channel);
    assign live       = (32'(item_reg.channel) < CHANNELS);
    assign out_free   = !result_valid_reg || result_ready;
    assign commit     = (state_reg == ST_CALC) && out_free;
    assign cur_state  = rd_valid_reg ? rd_data_reg : RESET_STATE;

    gccn_update u_update
    (
        .item  (item_reg),
        .cur   (cur_state),
        .nxt   (new_state),
        .flags (flags)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            written_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit && live)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
            if (commit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= '{action:          action,
                              channel:         channel,
                              carrier_word:    carrier_word,
                              code_word:       code_word,
                              start_chip:      start_chip,
                              start_ms:        start_ms,
                              start_bit_count: start_bit_count,
                              code_length:     code_length,
                              ms_per_bit:      ms_per_bit,
                              nav_word:        nav_word};
            rd_data_reg  <= mem[rd_idx];
            rd_valid_reg <= written_reg[rd_idx];
        end
        if (commit && live)
        begin
            mem[wr_idx] <= new_state;
        end
        if (commit)
        begin
            out_channel_reg <= item_reg.channel;
            out_state_reg   <= live ? new_state : '0;
            out_flags_reg   <= live ? flags : '0;
        end
    end

    assign result_valid  = result_valid_reg;
    assign out_channel   = out_channel_reg;
    assign carrier_phase = out_state_reg.carrier_acc;
    assign code_phase    = out_state_reg.code_acc;
    assign chip_index    = out_state_reg.chip_count;
    assign ms_index      = out_state_reg.period_count;
    assign bit_count     = out_state_reg.bits_left;
    assign nav_bit       = out_state_reg.current_bit;
    assign word_request  = out_flags_reg.word_request;
    assign chip_edge     = out_flags_reg.chip_edge;

endmodule

[rtl/gccn_update.sv]
// Per-channel state update for set-up, word load and tick actions.
module gccn_update
    import gccn_pkg::*;
(
    input  item_t       item,
    input  chan_state_t cur,
    output chan_state_t nxt,
    output tick_flags_t flags
);

    logic [32:0] code_sum;
    logic [11:0] chip_inc;
    logic [5:0]  period_inc;
    logic [5:0]  k;

    always_comb
    begin
        nxt        = cur;
        flags      = '0;
        code_sum   = {1'b0, cur.code_acc} + {1'b0, item.code_word};
        chip_inc   = cur.chip_count + 12'd1;
        period_inc = cur.period_count + 6'd1;
        k          = (cur.bits_left == 6'd0) ? 6'd0 : cur.bits_left - 6'd1;
        if (k > WORD_BITS - 6'd1)
        begin
            k = WORD_BITS - 6'd1;
        end

        case (action_t'(item.action))
            ACT_SETUP:
            begin
                nxt.carrier_acc  = item.carrier_word;
                nxt.code_acc     = item.code_word;
                nxt.chip_count   = item.start_chip;
                nxt.period_count = item.start_ms;
                nxt.bits_left    = (item.start_bit_count == 6'd0 ||
                                    item.start_bit_count > WORD_BITS) ?
                                   WORD_BITS : item.start_bit_count;
                nxt.chips_per_period = (item.code_length == 12'd0) ?
                                       12'd1 : item.code_length;
                nxt.periods_per_bit  = (item.ms_per_bit == 6'd0) ?
                                       6'd1 : item.ms_per_bit;
                nxt.word_valid   = 1'b0;
                nxt.current_bit  = 1'b0;
            end
            ACT_LOAD:
            begin
                nxt.bit_store  = item.nav_word;
                nxt.word_valid = 1'b1;
            end
            ACT_TICK:
            begin
                nxt.carrier_acc = cur.carrier_acc + item.carrier_word;
                nxt.code_acc    = code_sum[31:0];
                if (code_sum[32])
                begin
                    flags.chip_edge = 1'b1;
                    nxt.chip_count  = chip_inc;
                    if (chip_inc >= cur.chips_per_period || chip_inc == 12'd0)
                    begin
                        nxt.chip_count   = 12'd0;
                        nxt.period_count = period_inc;
                        if (period_inc >= cur.periods_per_bit || period_inc == 6'd0)
                        begin
                            nxt.period_count = 6'd0;
                            nxt.bits_left    = k;
                            if (cur.word_valid)
                            begin
                                nxt.current_bit = cur.bit_store[k[4:0]];
                            end
                            if (k == 6'd0)
                            begin
                                nxt.word_valid     = 1'b1;
                                flags.word_request = 1'b1;
                                nxt.bits_left      = WORD_BITS;
                            end
                        end
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule
